### rtl/core/drs_pkg.sv
// Package for the disk request scheduler.
// Holds the fixed field widths, status codes and policy codes; no dependencies.
package drs_pkg;

    localparam int ID_W     = 16;
    localparam int TRK_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 6;
    localparam int POL_W    = 3;

    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    localparam logic [POL_W-1:0] POL_FIFO  = 3'd0;
    localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
    localparam logic [POL_W-1:0] POL_LOOK  = 3'd2;
    localparam logic [POL_W-1:0] POL_CLOOK = 3'd3;
    localparam logic [POL_W-1:0] POL_FSCAN = 3'd4;

endpackage

### rtl/core/drs_ifs.sv
// Valid/ready channel interfaces of the disk request scheduler.
// Depends on drs_pkg for the payload widths.
interface drs_req_if
    import drs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [ID_W-1:0]  request_id;
    logic [TRK_W-1:0] track;

    modport source (output valid, action, request_id, track, input ready);
    modport sink   (input valid, action, request_id, track, output ready);
endinterface

interface drs_rsp_if
    import drs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     grant_id;
    logic [TRK_W-1:0]    grant_track;
    logic [TRK_W-1:0]    seek_distance;
    logic [CNT_W-1:0]    pending_count;

    modport source (output valid, status, grant_id, grant_track, seek_distance,
                    pending_count, input ready);
    modport sink   (input valid, status, grant_id, grant_track, seek_distance,
                    pending_count, output ready);
endinterface

interface drs_cfg_if
    import drs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/disk_request_scheduler.sv
// Disk request scheduler top level.
// Depends on drs_pkg and the channel interfaces in drs_ifs.sv.
//
// Usage: words on req carry an action (add or dispatch), a request id and a
// track. Every accepted word yields exactly one word on rsp with a status,
// the granted id and track, the seek distance and the pending count.
// The cfg channel writes the scheduling policy; it is always ready. The user
// writes it only while the block is idle; the block does not enforce this.
// The request table lives in two synchronous memories that are scanned one
// entry per cycle. An add searches the valid bits for a free slot, stepping past
// each occupied slot ahead of it. A dispatch scans all QUEUE_DEPTH entries,
// reads the winner back, and then sweeps all entries again to renumber the
// age ranks. A dispatch on an empty table and an add to a full table skip
// the search and go straight to the result.
// The rsp output is registered: the next req word is accepted while a
// result still waits, and the block holds its following result until the
// receiver takes the pending one.
// Reset empties the table, puts the head at track zero, the sweep upward,
// bank zero active and the policy to FIFO.
module disk_request_scheduler
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TRACK_BITS  = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    drs_req_if.sink    req,
    drs_rsp_if.source  rsp,
    drs_cfg_if.sink    cfg
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_GRANT = 3'd5;
    localparam logic [2:0] S_SWEEP = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int C_OLD  = 0;
    localparam int C_NEAR = 1;
    localparam int C_UP   = 2;
    localparam int C_DOWN = 3;
    localparam int C_LOW  = 4;

    typedef struct packed {
        logic                  bank;
        logic [ID_W-1:0]       ident;
        logic [TRACK_BITS-1:0] track;
    } entry_t;

    typedef struct packed {
        logic                  found;
        logic [IW-1:0]         idx;
        logic [TRACK_BITS-1:0] key;
        logic [TRACK_BITS-1:0] track;
        logic [IW-1:0]         rank;
    } cand_t;

    entry_t        ent_mem [QUEUE_DEPTH];
    logic [IW-1:0] rank_mem [QUEUE_DEPTH];
    entry_t        ent_rd_reg;
    logic [IW-1:0] rank_rd_reg;

    logic [2:0]              state_reg, state_next;
    logic [QUEUE_DEPTH-1:0]  valid_reg;
    logic [OW-1:0]           occ_reg;
    logic [OW-1:0]           bank_cnt_reg [2];
    logic                    active_bank_reg;
    logic                    sweep_up_reg;
    logic [TRACK_BITS-1:0]   head_reg;
    logic [POL_W-1:0]        policy_reg;
    logic                    bank_only_reg;

    logic [IW-1:0]           ctr_reg;
    logic                    iss_done_reg;
    logic                    rd_vld_reg;
    logic                    rd_last_reg;
    logic [IW-1:0]           rd_idx_reg;

    logic [ID_W-1:0]         in_id_reg;
    logic [TRACK_BITS-1:0]   in_trk_reg;

    cand_t                   cand_reg [5];
    cand_t                   cand_next [5];
    cand_t                   win_reg;

    logic [STATUS_W-1:0]     res_status_reg;
    logic [ID_W-1:0]         res_id_reg;
    logic [TRACK_BITS-1:0]   res_track_reg;
    logic [TRACK_BITS-1:0]   res_seek_reg;

    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     rsp_status_reg;
    logic [ID_W-1:0]         rsp_id_reg;
    logic [TRK_W-1:0]        rsp_track_reg;
    logic [TRK_W-1:0]        rsp_seek_reg;
    logic [CNT_W-1:0]        rsp_count_reg;

    logic                    req_fire;
    logic                    issue;
    logic [IW-1:0]           raddr;
    logic                    elig;
    logic                    rank_we;
    logic [IW-1:0]           rank_waddr;
    logic [IW-1:0]           rank_wdata;
    logic                    ent_we;
    logic                    sel_up;
    cand_t                   sel;

    function automatic logic better(input logic f, input logic [TRACK_BITS-1:0] k,
                                    input logic [IW-1:0] r,
                                    input logic [TRACK_BITS-1:0] bk,
                                    input logic [IW-1:0] br);
        return !f || (k < bk) || ((k == bk) && (r < br));
    endfunction

    function automatic cand_t upd(input cand_t c, input logic ok,
                                  input logic [TRACK_BITS-1:0] k,
                                  input logic [IW-1:0] idx,
                                  input logic [TRACK_BITS-1:0] t,
                                  input logic [IW-1:0] r);
        cand_t n;
        n = c;
        if (ok && better(c.found, k, r, c.key, c.rank))
        begin
            n.found = 1'b1;
            n.idx   = idx;
            n.key   = k;
            n.track = t;
            n.rank  = r;
        end
        return n;
    endfunction

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.grant_id      = rsp_id_reg;
    assign rsp.grant_track   = rsp_track_reg;
    assign rsp.seek_distance = rsp_seek_reg;
    assign rsp.pending_count = rsp_count_reg;

    assign issue = ((state_reg == S_SCAN) || (state_reg == S_SWEEP)) && !iss_done_reg;
    assign raddr = (state_reg == S_FETCH) ? win_reg.idx : ctr_reg;
    assign ent_we = (state_reg == S_ADD) && !valid_reg[ctr_reg];

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ctr_reg] <= '{bank: !active_bank_reg, ident: in_id_reg,
                                  track: in_trk_reg};
        end
        ent_rd_reg <= ent_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[raddr];
    end

    always_comb
    begin
        rank_we    = 1'b0;
        rank_waddr = ctr_reg;
        rank_wdata = IW'(occ_reg);
        if (ent_we)
        begin
            rank_we = 1'b1;
        end
        else if ((state_reg == S_SWEEP) && rd_vld_reg && valid_reg[rd_idx_reg] &&
                 (rank_rd_reg > win_reg.rank))
        begin
            rank_we    = 1'b1;
            rank_waddr = rd_idx_reg;
            rank_wdata = rank_rd_reg - 1'b1;
        end
    end

    always_comb
    begin
        elig = rd_vld_reg && valid_reg[rd_idx_reg] &&
               (!bank_only_reg || (ent_rd_reg.bank == active_bank_reg));
        cand_next[C_OLD]  = upd(cand_reg[C_OLD], elig, '0, rd_idx_reg,
                                ent_rd_reg.track, rank_rd_reg);
        cand_next[C_NEAR] = upd(cand_reg[C_NEAR], elig,
                                (ent_rd_reg.track >= head_reg) ?
                                ent_rd_reg.track - head_reg :
                                head_reg - ent_rd_reg.track,
                                rd_idx_reg, ent_rd_reg.track, rank_rd_reg);
        cand_next[C_UP]   = upd(cand_reg[C_UP], elig && (ent_rd_reg.track >= head_reg),
                                ent_rd_reg.track - head_reg, rd_idx_reg,
                                ent_rd_reg.track, rank_rd_reg);
        cand_next[C_DOWN] = upd(cand_reg[C_DOWN], elig && (ent_rd_reg.track <= head_reg),
                                head_reg - ent_rd_reg.track, rd_idx_reg,
                                ent_rd_reg.track, rank_rd_reg);
        cand_next[C_LOW]  = upd(cand_reg[C_LOW], elig, ent_rd_reg.track, rd_idx_reg,
                                ent_rd_reg.track, rank_rd_reg);
    end

    always_comb
    begin
        sel_up = sweep_up_reg;
        priority case (policy_reg)
            POL_SSTF:
            begin
                sel = cand_reg[C_NEAR];
            end
            POL_LOOK, POL_FSCAN:
            begin
                if (sweep_up_reg)
                begin
                    sel_up = cand_reg[C_UP].found;
                    sel = cand_reg[C_UP].found ? cand_reg[C_UP] : cand_reg[C_DOWN];
                end
                else
                begin
                    sel_up = !cand_reg[C_DOWN].found;
                    sel = cand_reg[C_DOWN].found ? cand_reg[C_DOWN] : cand_reg[C_UP];
                end
            end
            POL_CLOOK:
            begin
                sel = cand_reg[C_UP].found ? cand_reg[C_UP] : cand_reg[C_LOW];
            end
            default:
            begin
                sel = cand_reg[C_OLD];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.action == ACT_ADD)
                    begin
                        state_next = (occ_reg >= OW'(QUEUE_DEPTH)) ? S_DONE : S_ADD;
                    end
                    else
                    begin
                        state_next = (occ_reg == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_ADD:
            begin
                if (ent_we)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg && rd_last_reg)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = sel.found ? S_FETCH : S_DONE;
            end
            S_FETCH:
            begin
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (rd_vld_reg && rd_last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            occ_reg         <= '0;
            bank_cnt_reg[0] <= '0;
            bank_cnt_reg[1] <= '0;
            active_bank_reg <= 1'b0;
            sweep_up_reg    <= 1'b1;
            head_reg        <= '0;
            policy_reg      <= POL_FIFO;
            rsp_valid_reg   <= 1'b0;
            rd_vld_reg      <= 1'b0;
            iss_done_reg    <= 1'b0;
            ctr_reg         <= '0;
            for (int i = 0; i < 5; i++)
            begin
                cand_reg[i].found <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            rd_idx_reg  <= ctr_reg;
            rd_last_reg <= (ctr_reg == LAST_IDX);

            if (cfg.valid && cfg.ready)
            begin
                policy_reg <= cfg.data;
            end

            if (issue)
            begin
                if (ctr_reg == LAST_IDX)
                begin
                    iss_done_reg <= 1'b1;
                end
                else
                begin
                    ctr_reg <= ctr_reg + 1'b1;
                end
            end

            if ((state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        in_id_reg      <= req.request_id;
                        in_trk_reg     <= TRACK_BITS'(req.track);
                        ctr_reg        <= '0;
                        iss_done_reg   <= 1'b0;
                        res_id_reg     <= '0;
                        res_track_reg  <= '0;
                        res_seek_reg   <= '0;
                        bank_only_reg  <= (policy_reg == POL_FSCAN);
                        for (int i = 0; i < 5; i++)
                        begin
                            cand_reg[i].found <= 1'b0;
                        end
                        if (req.action == ACT_ADD)
                        begin
                            res_status_reg <= ST_FULL;
                        end
                        else
                        begin
                            res_status_reg <= ST_EMPTY;
                            if ((policy_reg == POL_FSCAN) && (occ_reg != '0) &&
                                (bank_cnt_reg[active_bank_reg] == '0))
                            begin
                                active_bank_reg <= !active_bank_reg;
                                sweep_up_reg    <= 1'b1;
                            end
                        end
                    end
                end
                S_ADD:
                begin
                    if (ent_we)
                    begin
                        valid_reg[ctr_reg] <= 1'b1;
                        occ_reg <= occ_reg + 1'b1;
                        bank_cnt_reg[!active_bank_reg] <=
                            bank_cnt_reg[!active_bank_reg] + 1'b1;
                        res_status_reg <= ST_ADDED;
                    end
                    else
                    begin
                        ctr_reg <= ctr_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    cand_reg <= cand_next;
                end
                S_PICK:
                begin
                    win_reg <= sel;
                    if ((policy_reg == POL_LOOK) || (policy_reg == POL_FSCAN))
                    begin
                        sweep_up_reg <= sel_up;
                    end
                end
                S_FETCH:
                begin
                end
                S_GRANT:
                begin
                    res_status_reg <= ST_DISPATCHED;
                    res_id_reg     <= ent_rd_reg.ident;
                    res_track_reg  <= win_reg.track;
                    res_seek_reg   <= (head_reg >= win_reg.track) ?
                                      head_reg - win_reg.track :
                                      win_reg.track - head_reg;
                    head_reg       <= win_reg.track;
                    valid_reg[win_reg.idx] <= 1'b0;
                    occ_reg        <= occ_reg - 1'b1;
                    bank_cnt_reg[ent_rd_reg.bank] <= bank_cnt_reg[ent_rd_reg.bank] - 1'b1;
                    ctr_reg        <= '0;
                    iss_done_reg   <= 1'b0;
                end
                S_SWEEP:
                begin
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_status_reg <= res_status_reg;
                        rsp_id_reg     <= res_id_reg;
                        rsp_track_reg  <= TRK_W'(res_track_reg);
                        rsp_seek_reg   <= TRK_W'(res_seek_reg);
                        rsp_count_reg  <= CNT_W'(occ_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/core/drs_checker.sv
// Port-level assertions for the disk request scheduler, bound to its top level.
// Depends on drs_pkg for the status codes and widths.
module drs_checker
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ID_W-1:0]     grant_id,
    input logic [TRK_W-1:0]    grant_track,
    input logic [TRK_W-1:0]    seek_distance,
    input logic [CNT_W-1:0]    pending_count
);

    // A word that has been taken must make the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while block still took words");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_DISPATCHED) |->
        (grant_id == '0) && (grant_track == '0) && (seek_distance == '0))
        else $error("grant fields set without a dispatch");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (pending_count == CNT_W'(QUEUE_DEPTH)))
        else $error("drop reported with room in the table");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EMPTY) |-> (pending_count == '0))
        else $error("nothing pending reported with requests queued");

endmodule

bind disk_request_scheduler drs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_drs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .grant_id      (rsp.grant_id),
    .grant_track   (rsp.grant_track),
    .seek_distance (rsp.seek_distance),
    .pending_count (rsp.pending_count)
);
